// File: src/continued_fraction_expansion_core_defines.svh
// assertion macros shared by the continued fraction expansion rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef CONTINUED_FRACTION_EXPANSION_CORE_DEFINES_SVH
`define CONTINUED_FRACTION_EXPANSION_CORE_DEFINES_SVH

// same-cycle implication under async low reset
`define CFE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under async low reset
`define CFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cfe_pkg.sv
// widths, sequencer states and term saturation for the continued fraction core
// no dependencies; imported by cfe_div and continued_fraction_expansion_core
package cfe_pkg;

	localparam int FRAC_BITS = 32;
	localparam int MAX_TERMS = 64;
	localparam int VALUE_W   = 64;
	localparam int TERM_W    = 34;
	localparam int IDX_W     = $clog2(MAX_TERMS);
	localparam int CNT_W     = 7;
	localparam int DIV_W     = FRAC_BITS + 1;
	localparam int DCNT_W    = $clog2(DIV_W);
	localparam int MAG0_W    = VALUE_W - FRAC_BITS;
	localparam int WIDE_W    = VALUE_W + 2;
	localparam int OUT_W     = ((TERM_W + IDX_W + 7) / 8) * 8;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam int APB_W     = 32;

	localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT   = '0;
	localparam logic [CNT_W-1:0]     TERM_COUNT_RESET = CNT_W'(16);

	localparam logic signed [WIDE_W-1:0] WIDE_ONE = WIDE_W'(1);
	localparam logic signed [WIDE_W-1:0] TERM_HI =
		{{(WIDE_W-TERM_W+1){1'b0}}, {(TERM_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] TERM_LO =
		{{(WIDE_W-TERM_W+1){1'b1}}, {(TERM_W-1){1'b0}}};

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_DIV,
		S_OUT
	} state_t;

	function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [WIDE_W-1:0] x);
		logic signed [TERM_W-1:0] r;
		if (x > TERM_HI) begin
			r = TERM_HI[TERM_W-1:0];
		end else if (x < TERM_LO) begin
			r = TERM_LO[TERM_W-1:0];
		end else begin
			r = x[TERM_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/cfe_div.sv
// restoring divider, one quotient bit per cycle, shared by every term that needs a division
// depends on cfe_pkg
module cfe_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cfe_pkg::DIV_W-1:0]     dividend,
	input  logic [cfe_pkg::FRAC_BITS-1:0] divisor,
	output logic                         busy,
	output logic                         done,
	output logic [cfe_pkg::DIV_W-1:0]     quotient,
	output logic [cfe_pkg::FRAC_BITS-1:0] remainder
);
	import cfe_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [DIV_W-1:0]    num_q;
	logic [FRAC_BITS-1:0] rem_q;
	logic [FRAC_BITS-1:0] den_q;

	logic [FRAC_BITS:0]   trial;
	logic [FRAC_BITS:0]   diff;
	logic                 ge;
	logic [FRAC_BITS-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, num_q[DIV_W-1]};
		diff     = trial - {1'b0, den_q};
		ge       = trial >= {1'b0, den_q};
		rem_next = ge ? diff[FRAC_BITS-1:0] : trial[FRAC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - DCNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

// File: src/continued_fraction_expansion_core.sv
// continued fraction expansion core: stream in, term stream out, apb register
// depends on cfe_pkg, cfe_div and continued_fraction_expansion_core_defines.svh
//
// Each input word is a signed Q32.32 value; the core answers with term_count
// output words (term_count taken as 1 when zero and 64 above 64), each holding
// one term of the simple continued fraction and its index, with tlast on the
// final one. Negative values come out as [-a0-1; 1, a1-1, a2, ...], with the
// a1 = 1 case folded into [-a0-1; a2+1, a3, ...] and negative integers as
// [-a0]; terms after the expansion ends are zero. The input is taken only when
// the core is idle. Term 0 is presented in the cycle after the input word is
// taken; every later term that needs a division comes from one 33-step
// restoring divider (the folded term needs two divisions), while terms after
// the end and the a1-1 term after the inserted 1 are made without it, and an
// output stall holds each term until it is taken. term_count sits at byte
// address 0 and resets to 16.
`include "continued_fraction_expansion_core_defines.svh"

module continued_fraction_expansion_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// value
	input  logic [cfe_pkg::VALUE_W-1:0]    s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// term, term_index
	output logic [cfe_pkg::OUT_W-1:0]      m_tdata,
	output logic                          m_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cfe_pkg::ADDR_W-1:0]     paddr,
	input  logic [cfe_pkg::APB_W-1:0]      pwdata,
	output logic [cfe_pkg::APB_W-1:0]      prdata,
	output logic                          pready
);
	import cfe_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]      term_count_q;
	logic [IDX_W-1:0]      cnt_m1;

	logic                  neg_q, frac_q, ended_q, first_q, merge_q, pend_q;
	logic [DIV_W-1:0]      p_q;
	logic [FRAC_BITS-1:0]  q_q;
	logic [DIV_W-1:0]      hold_q;
	logic signed [TERM_W-1:0] term_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  last_q;

	logic                  div_start, div_busy, div_done;
	logic [DIV_W-1:0]      div_quot;
	logic [FRAC_BITS-1:0]  div_rem;

	logic [VALUE_W-1:0]    mag_abs;
	logic [MAG0_W-1:0]     mag0;
	logic [FRAC_BITS-1:0]  r0;
	logic signed [WIDE_W-1:0] mag0_w, seq0, quot_w, hold_w;
	logic                  split_div, fold_one;

	logic                  load_out;
	logic signed [TERM_W-1:0] term_d;
	logic [IDX_W-1:0]      idx_d;
	logic                  apb_wr;

	// register port
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RESET;
		end else if (apb_wr && (paddr[ADDR_W-1:2] == REG_TERM_COUNT)) begin
			term_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[ADDR_W-1:2] == REG_TERM_COUNT) ? APB_W'(term_count_q) : '0;

	always_comb begin
		if (term_count_q == '0) begin
			cnt_m1 = '0;
		end else if (term_count_q > CNT_W'(MAX_TERMS)) begin
			cnt_m1 = IDX_W'(MAX_TERMS - 1);
		end else begin
			cnt_m1 = IDX_W'(term_count_q - CNT_W'(1));
		end
	end

	// integer part straight from the input word
	always_comb begin
		mag_abs = s_tdata[VALUE_W-1] ? (~s_tdata + VALUE_W'(1)) : s_tdata;
		mag0    = mag_abs[VALUE_W-1:FRAC_BITS];
		r0      = mag_abs[FRAC_BITS-1:0];
		mag0_w  = $signed({{(WIDE_W-MAG0_W){1'b0}}, mag0});
		if (!s_tdata[VALUE_W-1]) begin
			seq0 = mag0_w;
		end else if (r0 != '0) begin
			seq0 = -mag0_w - WIDE_ONE;
		end else begin
			seq0 = -mag0_w;
		end
		quot_w    = $signed({{(WIDE_W-DIV_W){1'b0}}, div_quot});
		hold_w    = $signed({{(WIDE_W-DIV_W){1'b0}}, hold_q});
		split_div = first_q && neg_q && frac_q;
		fold_one  = split_div && (div_quot == DIV_W'(1));
	end

	cfe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (p_q),
		.divisor   (q_q),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		term_d    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					load_out = 1'b1;
					term_d   = sat_term(seq0);
					state_d  = S_OUT;
				end
			end
			S_START: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					if (fold_one) begin
						state_d = S_START;
					end else begin
						load_out = 1'b1;
						term_d   = split_div ? TERM_W'(1) : sat_term(quot_w + (merge_q ? WIDE_ONE : '0));
						state_d  = S_OUT;
					end
				end
			end
			S_OUT: begin
				if (m_tready) begin
					priority if (last_q) begin
						state_d = S_IDLE;
					end else if (pend_q) begin
						load_out = 1'b1;
						term_d   = sat_term(hold_w - WIDE_ONE);
					end else if (ended_q) begin
						load_out = 1'b1;
						term_d   = merge_q ? TERM_W'(1) : '0;
					end else begin
						state_d = S_START;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign idx_d = (state_q == S_IDLE) ? '0 : idx_q + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q   <= 1'b0;
			frac_q  <= 1'b0;
			ended_q <= 1'b0;
			first_q <= 1'b0;
			merge_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (state_q == S_IDLE && s_tvalid) begin
				neg_q   <= s_tdata[VALUE_W-1];
				frac_q  <= r0 != '0;
				ended_q <= r0 == '0;
				first_q <= 1'b1;
				merge_q <= 1'b0;
				pend_q  <= 1'b0;
			end else if (state_q == S_DIV && div_done) begin
				ended_q <= div_rem == '0;
				first_q <= 1'b0;
				if (fold_one) begin
					merge_q <= 1'b1;
				end else if (split_div) begin
					pend_q <= 1'b1;
				end else begin
					merge_q <= 1'b0;
				end
			end else if (state_q == S_OUT && m_tready && !last_q) begin
				if (pend_q) begin
					pend_q <= 1'b0;
				end else if (ended_q) begin
					merge_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			p_q <= {1'b1, {FRAC_BITS{1'b0}}};
			q_q <= r0;
		end else if (state_q == S_DIV && div_done) begin
			p_q <= {1'b0, q_q};
			q_q <= div_rem;
			if (split_div) begin
				hold_q <= div_quot;
			end
		end
		if (load_out) begin
			term_q <= term_d;
			idx_q  <= idx_d;
			last_q <= idx_d == cnt_m1;
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = state_q == S_OUT;
	assign m_tlast  = last_q;

	always_comb begin
		m_tdata                 = '0;
		m_tdata[TERM_W-1:0]     = term_q;
		m_tdata[TERM_W+:IDX_W]  = idx_q;
	end

	`CFE_ASSERT_SAME(a_ready_only_idle, clk, arst_n, s_tready, !m_tvalid && !div_busy, "input ready while a word is in flight")
	`CFE_ASSERT_NEXT(a_last_frees_input, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready, "core not idle after last term")
	`CFE_ASSERT_NEXT(a_more_terms_busy, clk, arst_n, m_tvalid && m_tready && !m_tlast, !s_tready, "core went idle before last term")
	`CFE_ASSERT_SAME(a_done_in_div, clk, arst_n, div_done, state_q == S_DIV, "divider result outside divide state")

endmodule
